// ----- src/chbd_pkg.sv -----
// Package for the canonical Huffman bit decoder: field widths, item kinds, shared types.
package chbd_pkg;

	// Payload widths of the input item
	localparam int KIND_W      = 2;
	localparam int LEN_IN_W    = 5;
	localparam int COUNT_W     = 9;
	localparam int INDEX_W     = 8;
	localparam int SYMBOL_IN_W = 9;

	// Payload widths of the result item
	localparam int SYMBOL_OUT_W = 9;
	localparam int OUT_LEN_W    = 5;

	// Parameter defaults
	localparam int DEF_MAX_CODE_LENGTH = 16;
	localparam int DEF_TABLE_DEPTH     = 256;
	localparam int DEF_SYMBOL_BITS     = 9;

	// Item kinds; the fourth code is ignored
	localparam logic [KIND_W-1:0] KIND_LOAD_COUNT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_SYMBOL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DECODE      = 2'd2;

	// Outcome of one decode bit, from the code walker to the result pipeline
	typedef struct packed {
		logic                 fire;  // bit completes a code or fails
		logic                 err;   // no valid code
		logic [OUT_LEN_W-1:0] len;   // code length, zero on error
	} walk_res_t;

endpackage

// ----- src/chbd_stream_if.sv -----
// Valid/ready channels for decoder items and decoded results.
interface chbd_in_if;
	logic                              valid;
	logic                              ready;
	logic [chbd_pkg::KIND_W-1:0]       kind;
	logic [chbd_pkg::LEN_IN_W-1:0]     code_length;
	logic [chbd_pkg::COUNT_W-1:0]      length_count;
	logic [chbd_pkg::INDEX_W-1:0]      table_index;
	logic [chbd_pkg::SYMBOL_IN_W-1:0]  symbol_value;
	logic                              bit_req;

	modport source (output valid, kind, code_length, length_count, table_index, symbol_value,
		bit_req, input ready);
	modport sink (input valid, kind, code_length, length_count, table_index, symbol_value,
		bit_req, output ready);
endinterface

interface chbd_out_if;
	logic                              valid;
	logic                              ready;
	logic [chbd_pkg::SYMBOL_OUT_W-1:0] symbol;
	logic [chbd_pkg::OUT_LEN_W-1:0]    decoded_length;
	logic                              error;

	modport source (output valid, symbol, decoded_length, error, input ready);
	modport sink (input valid, symbol, decoded_length, error, output ready);
endinterface

// ----- src/chbd_symbol_mem.sv -----
// Symbol table: one write port, one read port, registered read data.
module chbd_symbol_mem #(
	parameter int DEPTH = chbd_pkg::DEF_TABLE_DEPTH,
	parameter int WIDTH = chbd_pkg::DEF_SYMBOL_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read in one clocked block; one transfer per cycle keeps them apart
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/chbd_code_walker.sv -----
// Code walker: per-length counts, partial code state and the per-bit match test.
module chbd_code_walker #(
	parameter int MAX_CODE_LENGTH = chbd_pkg::DEF_MAX_CODE_LENGTH,
	parameter int TABLE_DEPTH     = chbd_pkg::DEF_TABLE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [chbd_pkg::KIND_W-1:0]          kind,
	input  logic [chbd_pkg::LEN_IN_W-1:0]        code_length,
	input  logic [chbd_pkg::COUNT_W-1:0]         length_count,
	input  logic                                 bit_req,
	output chbd_pkg::walk_res_t                  res,
	output logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr
);

	localparam int LW   = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
	localparam int BW   = $clog2(MAX_CODE_LENGTH + 1);
	localparam int FW   = MAX_CODE_LENGTH + 1;
	localparam int CMPW = FW + chbd_pkg::COUNT_W + 2;
	localparam int IBW  = $clog2(MAX_CODE_LENGTH * (2 ** chbd_pkg::COUNT_W));
	localparam int IDXW = IBW + 1;
	localparam int AW   = $clog2(TABLE_DEPTH);

	logic [chbd_pkg::COUNT_W-1:0] count_q [MAX_CODE_LENGTH];
	logic [MAX_CODE_LENGTH-1:0]   partial_q;
	logic [BW-1:0]                taken_q;
	logic [FW-1:0]                first_q;
	logic [IBW-1:0]               base_q;

	logic [BW-1:0]                len;
	logic [chbd_pkg::COUNT_W-1:0] cnt;
	logic [MAX_CODE_LENGTH-1:0]   code;
	logic [CMPW-1:0]              code_x;
	logic [CMPW-1:0]              first_x;
	logic [CMPW-1:0]              cnt_x;
	logic [CMPW-1:0]              diff;
	logic [CMPW-1:0]              next_first_x;
	logic [FW-1:0]                next_first;
	logic [IDXW-1:0]              idx;
	logic [MAX_CODE_LENGTH-1:0]   nonzero;
	logic                         hit;
	logic                         in_range;
	logic                         longer;
	logic                         last;
	logic                         dead;
	logic                         count_ok;

	// Lengths that still hold codes
	always_comb begin
		for (int k = 0; k < MAX_CODE_LENGTH; k++) begin
			nonzero[k] = (count_q[k] != '0);
		end
	end

	// Match test for the incoming bit at the current length
	always_comb begin
		len     = taken_q + BW'(1);
		cnt     = count_q[LW'(taken_q)];
		code    = MAX_CODE_LENGTH'({partial_q, bit_req});
		code_x  = CMPW'(code);
		first_x = CMPW'(first_q);
		cnt_x   = CMPW'(cnt);
		diff    = code_x - first_x;
		hit     = (code_x >= first_x) && (diff < cnt_x);
		idx     = IDXW'(base_q) + IDXW'(diff);
		in_range = (32'(idx) < 32'(TABLE_DEPTH));
		longer  = |(nonzero >> len);
		last    = (len >= BW'(MAX_CODE_LENGTH));
		dead    = !hit && (last || !longer);
		// once the first code passes every code of its length it stays out of reach
		next_first_x = (first_x + cnt_x) << 1;
		next_first   = (next_first_x > CMPW'({FW{1'b1}})) ? {FW{1'b1}} : FW'(next_first_x);
		count_ok = (code_length != '0) && (32'(code_length) <= 32'(MAX_CODE_LENGTH));
	end

	assign res.fire = (kind == chbd_pkg::KIND_DECODE) && (hit || dead);
	assign res.err  = dead || (hit && !in_range);
	assign res.len  = (hit && in_range) ? chbd_pkg::OUT_LEN_W'(len) : '0;
	assign rd_addr  = AW'(idx);

	// Count table and partial code state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_CODE_LENGTH; k++) begin
				count_q[k] <= '0;
			end
			partial_q <= '0;
			taken_q   <= '0;
			first_q   <= '0;
			base_q    <= '0;
		end else if (accept) begin
			unique case (kind)
				chbd_pkg::KIND_LOAD_COUNT: begin
					if (count_ok) begin
						count_q[LW'(code_length - chbd_pkg::LEN_IN_W'(1))] <= length_count;
					end
					partial_q <= '0;
					taken_q   <= '0;
					first_q   <= '0;
					base_q    <= '0;
				end
				chbd_pkg::KIND_LOAD_SYMBOL: begin
					partial_q <= '0;
					taken_q   <= '0;
					first_q   <= '0;
					base_q    <= '0;
				end
				chbd_pkg::KIND_DECODE: begin
					if (hit || dead) begin
						partial_q <= '0;
						taken_q   <= '0;
						first_q   <= '0;
						base_q    <= '0;
					end else begin
						partial_q <= code;
						taken_q   <= len;
						first_q   <= next_first;
						base_q    <= base_q + IBW'(cnt);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// A stored partial code is always shorter than the longest code
	a_taken_short: assert property (@(posedge clk) disable iff (!arst_n)
		taken_q < BW'(MAX_CODE_LENGTH))
		else $error("partial code reached the maximum length");

	// A load abandons the partial code
	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (kind == chbd_pkg::KIND_LOAD_COUNT || kind == chbd_pkg::KIND_LOAD_SYMBOL)
		|=> taken_q == '0 && partial_q == '0)
		else $error("load left a partial code behind");

	// Overrun of the longest length always ends the code
	a_last_fires: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == chbd_pkg::KIND_DECODE && last |-> res.fire)
		else $error("bit at the longest length did not end the code");

endmodule

// ----- src/canonical_huffman_bit_decoder_unit.sv -----
// Top level of the canonical Huffman bit decoder: walker, symbol memory, result pipeline.
//
// Usage: items arrive on the items channel, one code bit or one table load per transfer.
// Count loads (per code length) and symbol loads (canonical order) set up the table; each
// load also abandons any partial code. Decode items feed one bit each, most significant
// first. A bit that completes a code yields one result (symbol and length); a bit that can
// no longer form a code, or lands beyond the table, yields one result with error set and
// zero symbol and length. Bits that only extend the code and all loads give no result.
// A result leaves on the results channel after the deciding bit is transferred, through the
// match test in the transfer cycle, the symbol memory read and the output register.
// Throughput: one item per cycle while items is ready; the per-bit match test updates the
// walker state in the same cycle, and the symbol memory read sits in a pipeline stage behind it.
// Reset clears all code counts (empty table: every bit then yields an error) and the partial
// code; the symbol memory holds no defined contents until written.
// When the receiver stalls, the output register and the memory stage hold their results and
// items stays ready until both are full.
module canonical_huffman_bit_decoder_unit #(
	parameter int MAX_CODE_LENGTH = chbd_pkg::DEF_MAX_CODE_LENGTH,
	parameter int TABLE_DEPTH     = chbd_pkg::DEF_TABLE_DEPTH,
	parameter int SYMBOL_BITS     = chbd_pkg::DEF_SYMBOL_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	chbd_in_if.sink     items,
	chbd_out_if.source  results
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int SW = (SYMBOL_BITS < chbd_pkg::SYMBOL_IN_W) ? SYMBOL_BITS : chbd_pkg::SYMBOL_IN_W;

	chbd_pkg::walk_res_t res;
	logic [AW-1:0]       rd_addr;
	logic [SW-1:0]       rdata;
	logic                accept;
	logic                advance;
	logic                we;
	logic                re;

	logic                            valid_s1;
	logic                            err_s1;
	logic [chbd_pkg::OUT_LEN_W-1:0]  len_s1;

	logic                               out_valid_q;
	logic [chbd_pkg::SYMBOL_OUT_W-1:0]  symbol_q;
	logic [chbd_pkg::OUT_LEN_W-1:0]     length_q;
	logic                               error_q;

	// Handshake: the memory stage moves on when the output register is free or drains
	assign advance     = !out_valid_q || results.ready;
	assign items.ready = !valid_s1 || advance;
	assign accept      = items.valid && items.ready;

	chbd_code_walker #(
		.MAX_CODE_LENGTH (MAX_CODE_LENGTH),
		.TABLE_DEPTH     (TABLE_DEPTH)
	) u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.kind         (items.kind),
		.code_length  (items.code_length),
		.length_count (items.length_count),
		.bit_req      (items.bit_req),
		.res          (res),
		.rd_addr      (rd_addr)
	);

	// Symbol loads beyond the table are dropped
	assign we = accept && (items.kind == chbd_pkg::KIND_LOAD_SYMBOL)
		&& (32'(items.table_index) < 32'(TABLE_DEPTH));
	assign re = accept && res.fire && !res.err;

	chbd_symbol_mem #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (SW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(items.table_index)),
		.wdata (SW'(items.symbol_value)),
		.re    (re),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// Memory stage: control for the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= accept && res.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1 <= res.err;
			len_s1 <= res.len;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			symbol_q <= err_s1 ? '0 : chbd_pkg::SYMBOL_OUT_W'(rdata);
			length_q <= len_s1;
			error_q  <= err_s1;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.symbol         = symbol_q;
	assign results.decoded_length = length_q;
	assign results.error          = error_q;

	// Loads and unknown kinds never put a result into the pipeline
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && items.kind != chbd_pkg::KIND_DECODE |=> !valid_s1)
		else $error("non-decode item produced a result");

	// Input is held back only when both result stages are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!items.ready |-> valid_s1 && out_valid_q)
		else $error("input stalled with room in the pipeline");

	// A decoded symbol always carries a nonzero length
	a_ok_has_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !error_q |-> length_q != '0)
		else $error("successful result with zero length");

	// An error result carries zero symbol and length
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_q |-> symbol_q == '0 && length_q == '0)
		else $error("error result with nonzero payload");

endmodule

// ----- tb/tb_canonical_huffman_bit_decoder_unit.sv -----
// Self-checking bench for the canonical Huffman bit decoder: stimulus, code walker, checks.
module tb_canonical_huffman_bit_decoder_unit;
	import chbd_pkg::*;

	localparam int MAX_LEN     = DEF_MAX_CODE_LENGTH;
	localparam int TABLE_SIZE  = DEF_TABLE_DEPTH;
	localparam int ITEM_TARGET = 1450;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 60;
	localparam int DRAIN_WAIT  = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;
	// the fourth kind code has no package name: the block drops it
	localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [LEN_IN_W-1:0]    code_length;
		logic [COUNT_W-1:0]     length_count;
		logic [INDEX_W-1:0]     table_index;
		logic [SYMBOL_IN_W-1:0] symbol_value;
		logic                   bit_req;
	} code_item_t;

	typedef struct packed {
		logic [SYMBOL_OUT_W-1:0] symbol;
		logic [OUT_LEN_W-1:0]    len;
		logic                    err;
	} decoded_t;

	typedef int index_list_t[$];

	// Tracks the canonical code walk and holds the decoded symbols still due
	class code_walk_checker;
		logic [COUNT_W-1:0]      code_count [MAX_LEN];
		logic [SYMBOL_OUT_W-1:0] symbol_mem [TABLE_SIZE];
		longint unsigned         partial;
		longint unsigned         first_code;
		longint unsigned         index_base;
		int unsigned             bits_taken;
		decoded_t                due_symbols[$];
		int n_bits, n_count_loads, n_symbol_loads, n_ignored;
		int n_checked, n_errors, longest, mismatches;

		function new();
			foreach (code_count[k])
				code_count[k] = '0;
			abandon_code();
			n_bits = 0;
			n_count_loads = 0;
			n_symbol_loads = 0;
			n_ignored = 0;
			n_checked = 0;
			n_errors = 0;
			longest = 0;
			mismatches = 0;
		endfunction

		function void abandon_code();
			partial = 0;
			first_code = 0;
			index_base = 0;
			bits_taken = 0;
		endfunction

		// Append one expected result to the due list
		function void queue_result(decoded_t r);
			due_symbols = {due_symbols, r};
		endfunction

		// One code bit: match at the current length, give up, or extend the partial code
		function void walk_bit(logic b);
			int unsigned     len;
			longint unsigned code, cnt, idx;
			bit              longer;
			decoded_t        res;
			len = (bits_taken + 1 > MAX_LEN) ? MAX_LEN : bits_taken + 1;
			code = (partial << 1) | b;
			cnt = code_count[len-1];
			res = '0;
			if (code >= first_code && code - first_code < cnt) begin
				idx = index_base + (code - first_code);
				if (idx < TABLE_SIZE) begin
					res.symbol = symbol_mem[idx];
					res.len = OUT_LEN_W'(len);
					if (len > longest)
						longest = len;
				end else begin
					res.err = 1'b1;
				end
				queue_result(res);
				abandon_code();
				return;
			end
			longer = 1'b0;
			for (int k = len; k < MAX_LEN; k++)
				if (code_count[k] != 0)
					longer = 1'b1;
			if (len >= MAX_LEN || !longer) begin
				res.err = 1'b1;
				queue_result(res);
				abandon_code();
				return;
			end
			index_base += cnt;
			first_code = (first_code + cnt) << 1;
			partial = code;
			bits_taken = len;
		endfunction

		// Called on every accepted input transfer
		function void note_item(code_item_t it);
			case (it.kind)
				KIND_LOAD_COUNT: begin
					if (it.code_length >= 1 && it.code_length <= MAX_LEN)
						code_count[it.code_length - 1] = it.length_count;
					abandon_code();
					n_count_loads++;
				end
				KIND_LOAD_SYMBOL: begin
					if (it.table_index < TABLE_SIZE)
						symbol_mem[it.table_index] = SYMBOL_OUT_W'(it.symbol_value);
					abandon_code();
					n_symbol_loads++;
				end
				KIND_DECODE: begin
					walk_bit(it.bit_req);
					n_bits++;
				end
				default: n_ignored++;
			endcase
		endfunction

		// Called on every accepted result transfer
		function void check_result(decoded_t got);
			decoded_t want;
			n_checked++;
			if (got.err === 1'b1)
				n_errors++;
			if (due_symbols.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d arrived with none due: symbol %0d length %0d error %0b",
						n_checked, got.symbol, got.len, got.err);
				return;
			end
			want = due_symbols.pop_front();
			if (got.symbol !== want.symbol || got.len !== want.len || got.err !== want.err) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d mismatch: symbol %0d/%0d length %0d/%0d error %0b/%0b %s",
						n_checked, want.symbol, got.symbol, want.len, got.len,
						want.err, got.err, "(expected/actual)");
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	int               cycle_count = 0;
	int               items_sent = 0;
	bit               steady = 1'b0;
	code_walk_checker walker;

	chbd_in_if  items_ch ();
	chbd_out_if results_ch ();

	canonical_huffman_bit_decoder_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_canonical_huffman_bit_decoder_unit: done, errors");
			$finish;
		end
	end

	function automatic index_list_t scrambled(int n);
		index_list_t q;
		int          j, t;
		for (int i = 0; i < n; i++)
			q = {q, i};
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = q[i];
			q[i] = q[j];
			q[j] = t;
		end
		return q;
	endfunction

	function automatic code_item_t random_item();
		code_item_t it;
		it.kind = KIND_W'($urandom_range(0, 3));
		it.code_length = LEN_IN_W'($urandom_range(0, 31));
		it.length_count = COUNT_W'($urandom_range(0, 256));
		it.table_index = INDEX_W'($urandom);
		it.symbol_value = SYMBOL_IN_W'($urandom);
		it.bit_req = 1'($urandom);
		return it;
	endfunction

	function automatic code_item_t count_item(int len, int cnt);
		code_item_t it;
		it = random_item();
		it.kind = KIND_LOAD_COUNT;
		it.code_length = LEN_IN_W'(len);
		it.length_count = COUNT_W'(cnt);
		return it;
	endfunction

	function automatic code_item_t symbol_item(int idx, int sym);
		code_item_t it;
		it = random_item();
		it.kind = KIND_LOAD_SYMBOL;
		it.table_index = INDEX_W'(idx);
		it.symbol_value = SYMBOL_IN_W'(sym);
		return it;
	endfunction

	function automatic code_item_t bit_item(logic b);
		code_item_t it;
		it = random_item();
		it.kind = KIND_DECODE;
		it.bit_req = b;
		return it;
	endfunction

	function automatic code_item_t ignored_item();
		code_item_t it;
		it = random_item();
		it.kind = KIND_IGNORED;
		return it;
	endfunction

	// One input transfer, with an occasional idle cycle in front of it
	task automatic send_item(code_item_t it);
		if (!steady && $urandom_range(99) < 15) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid        <= 1'b1;
		items_ch.kind         <= it.kind;
		items_ch.code_length  <= it.code_length;
		items_ch.length_count <= it.length_count;
		items_ch.table_index  <= it.table_index;
		items_ch.symbol_value <= it.symbol_value;
		items_ch.bit_req      <= it.bit_req;
		do @(posedge clk); while (items_ch.ready !== 1'b1);
		walker.note_item(it);
		if (it.kind != KIND_IGNORED)
			items_sent++;
	endtask

	// Random code-length profile, loaded in scrambled order; mostly prefix-free,
	// now and then oversubscribed
	task automatic load_code_set();
		index_list_t order;
		int          counts [MAX_LEN];
		int          avail, total, cap, deepest, lim, r;
		bit          oversub;
		oversub = ($urandom_range(99) < 8);
		r = $urandom_range(99);
		deepest = (r < 60) ? $urandom_range(1, 6) :
			(r < 85) ? $urandom_range(7, 12) : $urandom_range(13, MAX_LEN);
		cap = ($urandom_range(99) < 80) ? 24 : 64;
		avail = 1;
		total = 0;
		for (int len = 1; len <= MAX_LEN; len++) begin
			counts[len-1] = 0;
			if (oversub) begin
				if ($urandom_range(3) == 0)
					counts[len-1] = $urandom_range(0, 256);
			end else if (len <= deepest && avail > 0) begin
				avail = avail * 2;
				lim = (cap - total < avail) ? cap - total : avail;
				if (len == deepest)
					counts[len-1] = $urandom_range(1) ? lim : $urandom_range(0, lim);
				else
					counts[len-1] = $urandom_range(0, (lim == avail) ? lim - 1 : lim);
				avail -= counts[len-1];
				total += counts[len-1];
			end
		end
		order = scrambled(MAX_LEN);
		foreach (order[i])
			send_item(count_item(order[i] + 1, counts[order[i]]));
		// oversubscribed sets lean on the full table written earlier
		if (!oversub) begin
			order = scrambled(total);
			foreach (order[i])
				send_item(symbol_item(order[i], $urandom_range(0, 511)));
		end
	endtask

	// Random bit stream with a little noise mixed in
	task automatic decode_bits(int n);
		repeat (n) begin
			if ($urandom_range(99) < 4)
				send_item(random_item());
			else
				send_item(bit_item(1'($urandom)));
		end
	endtask

	// Result side: random back-pressure plus one long hold-off
	initial begin : result_sink
		int       hold_left;
		bit       hold_done;
		decoded_t got;
		results_ch.ready = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
				got.symbol = results_ch.symbol;
				got.len = results_ch.decoded_length;
				got.err = results_ch.error;
				walker.check_result(got);
			end
			if (!hold_done && walker.n_checked >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= steady || ($urandom_range(99) >= 15);
			end
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		index_list_t order;
		walker = new();
		items_ch.valid = 1'b0;
		items_ch.kind = KIND_DECODE;
		items_ch.code_length = '0;
		items_ch.length_count = '0;
		items_ch.table_index = '0;
		items_ch.symbol_value = '0;
		items_ch.bit_req = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: every bit is an error
		send_item(bit_item(1'b0));
		send_item(bit_item(1'b1));
		send_item(ignored_item());
		// count loads for lengths out of range leave the table empty
		send_item(count_item(0, 5));
		send_item(count_item(31, 256));
		send_item(bit_item(1'b1));
		// complete code: 0, 10, 110, 111
		send_item(count_item(1, 1));
		send_item(count_item(2, 1));
		send_item(count_item(3, 2));
		send_item(symbol_item(0, 0));
		send_item(symbol_item(1, 511));
		send_item(symbol_item(2, 256));
		send_item(symbol_item(3, 85));
		send_item(bit_item(1'b0));
		// dropped kind in the middle of a code keeps the partial code
		send_item(bit_item(1'b1));
		send_item(ignored_item());
		send_item(bit_item(1'b0));
		send_item(bit_item(1'b1));
		send_item(bit_item(1'b1));
		send_item(bit_item(1'b0));
		// a load part way through a code abandons it
		send_item(bit_item(1'b1));
		send_item(symbol_item(3, 170));
		send_item(bit_item(1'b1));
		send_item(bit_item(1'b1));
		send_item(bit_item(1'b1));

		// whole table written once so no decode reads an unwritten entry
		order = scrambled(TABLE_SIZE);
		foreach (order[i])
			send_item(symbol_item(order[i], $urandom_range(0, 511)));

		while (items_sent < ITEM_TARGET) begin
			steady = (items_sent >= 700 && items_sent < 1000);
			if ($urandom_range(99) < 85) begin
				load_code_set();
				decode_bits($urandom_range(20, 120));
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(random_item());
			end
		end
		steady = 1'b0;
		items_ch.valid <= 1'b0;

		while (walker.due_symbols.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d code bits, %0d count loads, %0d symbol loads, %0d dropped items",
			walker.n_bits, walker.n_count_loads, walker.n_symbol_loads, walker.n_ignored);
		$display("%0d results checked, %0d of them errors, longest code %0d bits, %0d mismatches",
			walker.n_checked, walker.n_errors, walker.longest, walker.mismatches);
		if (walker.mismatches == 0) begin
			$display("tb_canonical_huffman_bit_decoder_unit: done, clean");
		end else begin
			$display("tb_canonical_huffman_bit_decoder_unit: done, errors");
		end
		$finish;
	end

endmodule
